FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the sandpile block.
// Depends on nothing; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sandpile checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sandpile checker: next-cycle implication failed");

`endif

FILE: hw/rtl/sandpile_pkg.sv
// Shared types and constants of the sandpile toppling block.
// Used by the top level and its checker; depends on nothing.
package sandpile_pkg;

    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int LIMIT_W   = 16;
    localparam int GSIDE_W   = 7;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 40;
    localparam logic [GSIDE_W-1:0] GSIDE_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_DATA,
        S_BSETUP,
        S_BORDER,
        S_SWEEP_START,
        S_CELL_RD,
        S_CELL_CHK,
        S_NB_RD,
        S_NB_WR,
        S_NEXT,
        S_SWEEP_END,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        NB_NORTH = 2'd0,
        NB_EAST  = 2'd1,
        NB_SOUTH = 2'd2,
        NB_WEST  = 2'd3
    } t_nb;

endpackage

FILE: hw/rtl/sandpile_topple_sweeper_top.sv
// Abelian sandpile toppling engine: grain grid in one RAM, swept by a sequencer.
// Depends on sandpile_pkg and sandpile_ram.
//
//  channel  | dir | handshake                  | payload
//  s_axis   | in  | tvalid / tready            | tuser: operation; tdata: index, value, limit
//  m_axis   | out | tvalid / tready            | tdata: read_value, still_toppling
//  cfg      | in  | wen                        | wdata: grid_side
//
// Write: one RAM write. Read: a RAM read, then the output register.
// Run: zero the border cells, then per sweep read and check each interior cell; a
// toppling cell keeps its value mod 4 and adds a quarter to each of its four
// neighbours by a read and a write each; then post the result.
// Reset clears control state only; the grid is undefined until written.
// A finished result waits in the output register; the sequencer holds until it frees.
module sandpile_topple_sweeper_top
    import sandpile_pkg::*;
#(
    parameter int MAX_SIDE   = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [GSIDE_W-1:0]    i_cfg_wdata,   // grid_side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata, // cell_index, cell_value, sweep_limit, pad
    input  logic [1:0]            i_s_axis_tuser, // operation
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata  // read_value, still_toppling, pad
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > GSIDE_W) ? SIDE_W : GSIDE_W;
    localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W + 1 : IDX_W + 1;

    t_state r_state, n_state;

    logic [GSIDE_W-1:0]    r_grid_side;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_value;
    logic                  r_out_topple;
    logic                  r_rd_ok;
    logic [LIMIT_W-1:0]    r_left;
    logic                  r_any;
    logic                  r_last;
    logic [SIDE_W-1:0]     r_k;
    logic [1:0]            r_bsel;
    logic [ADDR_W-1:0]     r_top, r_bot, r_lft, r_rgt;
    logic [SIDE_W-1:0]     r_row, r_col;
    logic [ADDR_W-1:0]     r_at;
    t_nb                   r_nb;
    logic [COUNT_BITS-1:0] r_share;

    logic                  w_in_xfer;
    logic                  w_out_free;
    t_op                   w_op;
    logic [IDX_W-1:0]      w_idx;
    logic [VAL_W-1:0]      w_val;
    logic [LIMIT_W-1:0]    w_limit;
    logic [EXT_W-1:0]      w_idx_ext;
    logic                  w_in_range;
    logic [ADDR_W-1:0]     w_in_addr;
    logic [SIDE_W-1:0]     w_side;
    logic [SIDE_W-1:0]     w_side_m1;
    logic [2*SIDE_W-1:0]   w_prod;
    logic [ADDR_W-1:0]     w_side_a;
    logic [ADDR_W-1:0]     w_off;
    logic [ADDR_W-1:0]     w_nb_addr;
    logic [COUNT_BITS-1:0] w_sum;
    logic                  w_big;
    logic                  w_col_more, w_row_more, w_k_last;
    logic                  w_small;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    sandpile_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_op       = t_op'(i_s_axis_tuser);
    assign w_idx      = i_s_axis_tdata[IDX_W-1:0];
    assign w_val      = i_s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
    assign w_limit    = i_s_axis_tdata[IDX_W+VAL_W+LIMIT_W-1:IDX_W+VAL_W];
    assign w_idx_ext  = EXT_W'(w_idx);
    assign w_in_range = w_idx_ext < EXT_W'(DEPTH);
    assign w_in_addr  = w_idx_ext[ADDR_W-1:0];

    assign w_side    = (CMP_W'(r_grid_side) > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                                : SIDE_W'(r_grid_side);
    assign w_side_m1 = w_side - SIDE_W'(1);
    assign w_prod    = (2*SIDE_W)'(w_side_m1) * (2*SIDE_W)'(w_side);
    assign w_side_a  = ADDR_W'(w_side);
    assign w_small   = (SIDE_W + 1)'(w_side) < (SIDE_W + 1)'(3);

    assign w_off     = (r_nb == NB_NORTH || r_nb == NB_SOUTH) ? w_side_a : ADDR_W'(1);
    assign w_nb_addr = (r_nb == NB_NORTH || r_nb == NB_WEST) ? r_at - w_off : r_at + w_off;
    assign w_sum     = ram_rdata + r_share;
    assign w_big     = |ram_rdata[COUNT_BITS-1:2];

    assign w_col_more = ((SIDE_W + 1)'(r_col) + (SIDE_W + 1)'(2)) < (SIDE_W + 1)'(w_side);
    assign w_row_more = ((SIDE_W + 1)'(r_row) + (SIDE_W + 1)'(2)) < (SIDE_W + 1)'(w_side);
    assign w_k_last   = ((SIDE_W + 1)'(r_k) + (SIDE_W + 1)'(1)) == (SIDE_W + 1)'(w_side);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    unique case (w_op)
                        OP_RUN:  n_state = S_BSETUP;
                        OP_READ: n_state = S_RD_DATA;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_DATA: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_BSETUP: begin
                n_state = (w_side == '0) ? S_SWEEP_START : S_BORDER;
            end
            S_BORDER: begin
                if (r_bsel == 2'd3 && w_k_last) n_state = S_SWEEP_START;
            end
            S_SWEEP_START: begin
                n_state = (r_left == '0 || w_small) ? S_DONE : S_CELL_RD;
            end
            S_CELL_RD:  n_state = S_CELL_CHK;
            S_CELL_CHK: n_state = w_big ? S_NB_RD : S_NEXT;
            S_NB_RD:    n_state = S_NB_WR;
            S_NB_WR:    n_state = (r_nb == NB_WEST) ? S_NEXT : S_NB_RD;
            S_NEXT: begin
                n_state = (w_col_more || w_row_more) ? S_CELL_RD : S_SWEEP_END;
            end
            S_SWEEP_END: begin
                n_state = (!r_any || r_left == LIMIT_W'(1)) ? S_DONE : S_SWEEP_START;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port controls and input ready
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_at;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_at;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                ram_waddr = w_in_addr;
                ram_wdata = w_val[COUNT_BITS-1:0];
                ram_raddr = w_in_addr;
                ram_we    = w_in_xfer && w_op == OP_WRITE && w_in_range;
                ram_re    = w_in_xfer && w_op == OP_READ;
            end
            S_BORDER: begin
                ram_we = 1'b1;
                unique case (r_bsel)
                    2'd0:    ram_waddr = r_top;
                    2'd1:    ram_waddr = r_bot;
                    2'd2:    ram_waddr = r_lft;
                    default: ram_waddr = r_rgt;
                endcase
            end
            S_CELL_RD: begin
                ram_re = 1'b1;
            end
            S_CELL_CHK: begin
                ram_we    = w_big;
                ram_wdata = {{(COUNT_BITS-2){1'b0}}, ram_rdata[1:0]};
            end
            S_NB_RD: begin
                ram_re    = 1'b1;
                ram_raddr = w_nb_addr;
            end
            S_NB_WR: begin
                ram_we    = 1'b1;
                ram_waddr = w_nb_addr;
                ram_wdata = w_sum;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_side <= GSIDE_RESET;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) r_grid_side <= i_cfg_wdata;
            if ((r_state == S_RD_DATA || r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SWEEP_START && (r_left == '0 || w_small)) r_last <= 1'b0;
            if (r_state == S_SWEEP_END) r_last <= r_any;
        end
    end

    // Datapath: result payload, border pointers, sweep position
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_rd_ok <= w_in_range;
                r_left  <= w_limit;
            end
            S_RD_DATA: begin
                if (w_out_free) begin
                    r_out_value  <= r_rd_ok ? VAL_W'(ram_rdata) : '0;
                    r_out_topple <= 1'b0;
                end
            end
            S_BSETUP: begin
                r_k    <= '0;
                r_bsel <= 2'd0;
                r_top  <= '0;
                r_bot  <= ADDR_W'(w_prod);
                r_lft  <= '0;
                r_rgt  <= ADDR_W'(w_side_m1);
            end
            S_BORDER: begin
                r_bsel <= r_bsel + 2'd1;
                if (r_bsel == 2'd3) begin
                    r_k   <= r_k + SIDE_W'(1);
                    r_top <= r_top + ADDR_W'(1);
                    r_bot <= r_bot + ADDR_W'(1);
                    r_lft <= r_lft + w_side_a;
                    r_rgt <= r_rgt + w_side_a;
                end
            end
            S_SWEEP_START: begin
                r_row <= SIDE_W'(1);
                r_col <= SIDE_W'(1);
                r_at  <= w_side_a + ADDR_W'(1);
                r_any <= 1'b0;
            end
            S_CELL_CHK: begin
                r_share <= ram_rdata >> 2;
                r_nb    <= NB_NORTH;
                if (w_big) r_any <= 1'b1;
            end
            S_NB_WR: begin
                r_nb <= t_nb'(r_nb + 2'd1);
            end
            S_NEXT: begin
                if (w_col_more) begin
                    r_col <= r_col + SIDE_W'(1);
                    r_at  <= r_at + ADDR_W'(1);
                end else begin
                    r_col <= SIDE_W'(1);
                    r_row <= r_row + SIDE_W'(1);
                    r_at  <= r_at + ADDR_W'(3);
                end
            end
            S_SWEEP_END: begin
                r_left <= r_left - LIMIT_W'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_value  <= '0;
                    r_out_topple <= r_last;
                end
            end
            default: begin
                r_rd_ok <= r_rd_ok;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-VAL_W-1){1'b0}}, r_out_topple, r_out_value};

endmodule

FILE: hw/rtl/sandpile_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module sandpile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sandpile_chk.sv
// Port-level checker for the sandpile toppling block, bound to the top level.
// Depends on sandpile_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sandpile_chk
    import sandpile_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [1:0]            i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic w_in_xfer;

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    `ASSERT_NEXT(a_busy_after_result_item, i_clk, i_rst_n,
        w_in_xfer && (i_s_axis_tuser == OP_RUN || i_s_axis_tuser == OP_READ),
        !o_s_axis_tready)

    `ASSERT_NEXT(a_ready_after_write, i_clk, i_rst_n,
        w_in_xfer && i_s_axis_tuser == OP_WRITE, o_s_axis_tready)

    `ASSERT_IMPL(a_run_result_has_no_value, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[VAL_W],
        o_m_axis_tdata[VAL_W-1:0] == '0 && o_m_axis_tdata[OUT_DATA_W-1:VAL_W+1] == '0)

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind sandpile_topple_sweeper_top sandpile_chk u_sandpile_chk (.*);
